FILE: rtl/core/prt_pkg.sv
// prt_pkg: shared types, codes and widths for the pending request tracker.
// No dependencies; compile this file first.
package prt_pkg;

    // Field widths of the message header and the result
    localparam int KIND_W   = 3;
    localparam int ID_W     = 16;
    localparam int KEY_W    = 4 * ID_W;
    localparam int STATUS_W = 2;
    localparam int PCOUNT_W = 7;

    // Default number of table entries
    localparam int PRT_TABLE_DEPTH = 64;

    // Message kinds that touch the table; every other code passes
    localparam logic [KIND_W-1:0] KIND_REQUEST  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RESPONSE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    // Largest value the pending count field can show
    localparam logic [PCOUNT_W-1:0] PCOUNT_MAX = '1;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FINISH
    } prt_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;       // latch the incoming header, reset the search
        logic clear_step;  // invalidate one entry of the table
        logic scan_step;   // read one entry of the table
        logic commit;      // update the table and load the result register
    } prt_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic addr_last;   // walk address is at the last entry
        logic out_free;    // result register can take a new result
    } prt_stat_t;

endpackage

FILE: rtl/core/prt_if.sv
// prt_if: valid/ready channels for message headers and tracker results.
// Depends on prt_pkg for the field widths.
interface prt_msg_if import prt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   req_type;
    logic [ID_W-1:0]     service_id;
    logic [ID_W-1:0]     method_id;
    logic [ID_W-1:0]     client_id;
    logic [ID_W-1:0]     session_id;

    modport source (
        output valid, req_type, service_id, method_id, client_id, session_id,
        input  ready
    );
    modport sink (
        input  valid, req_type, service_id, method_id, client_id, session_id,
        output ready
    );
endinterface

interface prt_result_if import prt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                accept;
    logic [STATUS_W-1:0] status;
    logic [PCOUNT_W-1:0] pending_count;

    modport source (
        output valid, accept, status, pending_count,
        input  ready
    );
    modport sink (
        input  valid, accept, status, pending_count,
        output ready
    );
endinterface

FILE: rtl/core/prt_controller.sv
// prt_controller: sequencer for the clearing pass, the table walk and the commit.
// Depends on prt_pkg; drives prt_datapath through prt_cmd_t.
module prt_controller import prt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      valid,
    output logic      ready,
    input  prt_stat_t stat,
    output prt_cmd_t  cmd
);

    prt_state_t state_reg;
    prt_state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through clear, walk, last compare and commit
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.addr_last)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Drive the handshake and the datapath commands
    always_comb
    begin
        ready          = 1'b0;
        cmd.start      = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.scan_step  = 1'b0;
        cmd.commit     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                ready     = 1'b1;
                cmd.start = valid;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_LAST:
            begin
                cmd.scan_step = 1'b0;
            end
            ST_FINISH:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

    // Commands never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.clear_step, cmd.scan_step, cmd.commit}))
        else $error("prt_controller: overlapping datapath commands");

    // A transaction is taken only from the idle state and always starts a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && ready) |=> (state_reg == ST_SCAN))
        else $error("prt_controller: accepted transaction did not start a walk");

    // A commit always returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == ST_IDLE))
        else $error("prt_controller: commit did not return to idle");

endmodule

FILE: rtl/core/prt_datapath.sv
// prt_datapath: key table memory, walk address, match and free search, pending
// count and the result register. Depends on prt_pkg; commanded by prt_controller.
module prt_datapath import prt_pkg::*; #(
    parameter int TABLE_DEPTH = PRT_TABLE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  prt_cmd_t            cmd,
    output prt_stat_t           stat,
    input  logic [KIND_W-1:0]   req_type,
    input  logic [ID_W-1:0]     service_id,
    input  logic [ID_W-1:0]     method_id,
    input  logic [ID_W-1:0]     client_id,
    input  logic [ID_W-1:0]     session_id,
    output logic                result_valid,
    input  logic                result_ready,
    output logic                accept,
    output logic [STATUS_W-1:0] status,
    output logic [PCOUNT_W-1:0] pending_count
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int WW    = CW + PCOUNT_W;
    localparam int MEM_W = KEY_W + 1;
    localparam logic [AW-1:0] ADDR_LAST = AW'(TABLE_DEPTH - 1);

    // Table: valid flag on top of the key
    logic [MEM_W-1:0] mem [TABLE_DEPTH];

    logic [KIND_W-1:0]   kind_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [AW-1:0]       addr_reg;
    logic                rd_valid_reg;
    logic [AW-1:0]       rd_idx_reg;
    logic [MEM_W-1:0]    rd_data_reg;
    logic                hit_reg;
    logic [AW-1:0]       hit_idx_reg;
    logic                free_reg;
    logic [AW-1:0]       free_idx_reg;
    logic [CW-1:0]       count_reg;
    logic                out_valid_reg;
    logic                accept_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [PCOUNT_W-1:0] pcount_reg;

    logic                is_req;
    logic                is_resp;
    logic                rd_hit;
    logic                rd_free;
    logic                add_ok;
    logic                del_ok;
    logic                res_accept;
    logic [STATUS_W-1:0] res_status;
    logic [CW-1:0]       count_next;
    logic [WW-1:0]       count_wide;
    logic [PCOUNT_W-1:0] pcount_next;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [MEM_W-1:0]    mem_wdata;

    // Compare the entry read last cycle against the held key
    assign rd_hit  = rd_valid_reg && rd_data_reg[KEY_W] && (rd_data_reg[KEY_W-1:0] == key_reg);
    assign rd_free = rd_valid_reg && !rd_data_reg[KEY_W];

    // Decide the outcome from the search flags
    assign is_req  = (kind_reg == KIND_REQUEST);
    assign is_resp = (kind_reg == KIND_RESPONSE) || (kind_reg == KIND_ERROR);
    assign add_ok  = is_req && !hit_reg && free_reg;
    assign del_ok  = is_resp && hit_reg;

    always_comb
    begin
        res_accept = 1'b1;
        res_status = STATUS_OK;
        if (is_req)
        begin
            if (hit_reg)
            begin
                res_accept = 1'b0;
                res_status = STATUS_DUPLICATE;
            end
            else if (!free_reg)
            begin
                res_accept = 1'b0;
                res_status = STATUS_FULL;
            end
        end
        else if (is_resp && !hit_reg)
        begin
            res_accept = 1'b0;
            res_status = STATUS_NO_MATCH;
        end
    end

    // Update the count and saturate it into the result field
    always_comb
    begin
        count_next = count_reg;
        if (add_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign count_wide  = WW'(count_next);
    assign pcount_next = (count_wide > WW'(PCOUNT_MAX)) ? PCOUNT_MAX : count_wide[PCOUNT_W-1:0];

    // Single write port: clearing pass, new request, or removal
    assign mem_we    = cmd.clear_step || (cmd.commit && (add_ok || del_ok));
    assign mem_waddr = cmd.clear_step ? addr_reg : (add_ok ? free_idx_reg : hit_idx_reg);
    assign mem_wdata = add_ok ? {1'b1, key_reg} : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    // Latch the header, the index of each read and the result
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            kind_reg <= req_type;
            key_reg  <= {service_id, method_id, client_id, session_id};
        end
        if (cmd.scan_step)
        begin
            rd_idx_reg <= addr_reg;
        end
        if (cmd.commit)
        begin
            accept_reg <= res_accept;
            status_reg <= res_status;
            pcount_reg <= pcount_next;
        end
    end

    // Walk address, search flags, count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_step;

            if (cmd.start)
            begin
                addr_reg <= '0;
            end
            else if (cmd.clear_step || cmd.scan_step)
            begin
                addr_reg <= (addr_reg == ADDR_LAST) ? '0 : addr_reg + AW'(1);
            end

            // Keep the lowest matching and the lowest free entry
            if (cmd.start)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else
            begin
                if (rd_hit && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_idx_reg;
                end
                if (rd_free && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
            end

            if (cmd.commit)
            begin
                count_reg <= count_next;
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.addr_last = (addr_reg == ADDR_LAST);
    assign stat.out_free  = !out_valid_reg || result_ready;

    assign result_valid  = out_valid_reg;
    assign accept        = accept_reg;
    assign status        = status_reg;
    assign pending_count = pcount_reg;

    // The count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("prt_datapath: pending count above table depth");

    // A table-full drop only happens when every entry is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && is_req && !hit_reg && !free_reg) |-> (count_reg == CW'(TABLE_DEPTH)))
        else $error("prt_datapath: full reported with free entries");

    // A stored request raises the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && add_ok) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("prt_datapath: stored request did not raise the count");

    // A removal lowers the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && del_ok) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("prt_datapath: removal did not lower the count");

endmodule

FILE: rtl/core/pending_request_tracker.sv
// pending_request_tracker: table of requests awaiting a response, keyed by
// service, method, client and session. Depends on prt_pkg, prt_if,
// prt_controller and prt_datapath.
//
//   channel   role    transaction                                   handshake
//   msg       sink    req_type, service_id, method_id, client_id,   valid/ready
//                     session_id
//   result    source  accept, status, pending_count                 valid/ready
//
// Each transaction walks the table memory one entry per cycle through its
// single registered read port; after a last compare, a commit updates it.
// After reset a clearing pass invalidates every entry in turn;
// msg.ready stays low until it completes.
// A finished result waits in the output register; the next header is taken
// at once, and its commit waits only if that result is still not taken.
module pending_request_tracker import prt_pkg::*; #(
    parameter int TABLE_DEPTH = PRT_TABLE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    prt_msg_if.sink      msg,
    prt_result_if.source result
);

    prt_cmd_t  cmd;
    prt_stat_t stat;

    // Sequence the clearing pass, walk and commit
    prt_controller u_controller (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (msg.valid),
        .ready (msg.ready),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Hold the table, search it and register the result
    prt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (msg.req_type),
        .service_id    (msg.service_id),
        .method_id     (msg.method_id),
        .client_id     (msg.client_id),
        .session_id    (msg.session_id),
        .result_valid  (result.valid),
        .result_ready  (result.ready),
        .accept        (result.accept),
        .status        (result.status),
        .pending_count (result.pending_count)
    );

endmodule

FILE: tb/sv/prt_checker.sv
`timescale 1ns / 100ps
// prt_checker: watches the msg and result channels of the pending request tracker,
// mirrors its request table and compares every result. Depends on prt_pkg and prt_if.
module prt_checker import prt_pkg::*; #(
    parameter int TABLE_DEPTH = PRT_TABLE_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    prt_msg_if    msg,
    prt_result_if result,
    output int    fail_count,
    output int    awaiting,
    output int    checked,
    output int    dup_hits,
    output int    miss_hits,
    output int    full_hits,
    output int    peak_pending
);

    typedef struct packed {
        logic                accept;
        logic [STATUS_W-1:0] status;
        logic [PCOUNT_W-1:0] pending_count;
    } verdict_t;

    // Mirror of the request table
    logic [KEY_W-1:0] key_mirror [TABLE_DEPTH];
    bit               live_mirror [TABLE_DEPTH];
    int               live_total;

    // Verdicts of accepted headers, oldest first
    verdict_t verdict_q [$];

    // Apply one header to the mirror and return the verdict it earns
    function automatic verdict_t apply_header(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
        verdict_t v;
        int       hit;
        int       free_slot;
        v.accept  = 1'b1;
        v.status  = STATUS_OK;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (live_mirror[i] && key_mirror[i] == key && hit < 0)
                hit = i;
            if (!live_mirror[i] && free_slot < 0)
                free_slot = i;
        end
        if (kind == KIND_REQUEST)
        begin
            // a pending key wins over a full table
            if (hit >= 0)
            begin
                v.accept = 1'b0;
                v.status = STATUS_DUPLICATE;
            end
            else if (free_slot < 0)
            begin
                v.accept = 1'b0;
                v.status = STATUS_FULL;
            end
            else
            begin
                key_mirror[free_slot]  = key;
                live_mirror[free_slot] = 1'b1;
                live_total++;
            end
        end
        else if (kind == KIND_RESPONSE || kind == KIND_ERROR)
        begin
            if (hit < 0)
            begin
                v.accept = 1'b0;
                v.status = STATUS_NO_MATCH;
            end
            else
            begin
                live_mirror[hit] = 1'b0;
                key_mirror[hit]  = '0;
                if (live_total > 0)
                    live_total--;
            end
        end
        v.pending_count = (live_total > int'(PCOUNT_MAX)) ? PCOUNT_MAX
                                                          : PCOUNT_W'(live_total);
        return v;
    endfunction

    // Check results against the oldest verdict, then predict the new transaction
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t got;
        verdict_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                key_mirror[i]  = '0;
                live_mirror[i] = 1'b0;
            end
            live_total   = 0;
            verdict_q.delete();
            fail_count   = 0;
            awaiting     = 0;
            checked      = 0;
            dup_hits     = 0;
            miss_hits    = 0;
            full_hits    = 0;
            peak_pending = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.accept        = result.accept;
                got.status        = result.status;
                got.pending_count = result.pending_count;
                checked++;
                if (verdict_q.size() == 0)
                begin
                    $error("result with nothing expected: accept=%0d status=%0d pending_count=%0d",
                           got.accept, got.status, got.pending_count);
                    fail_count++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    case (want.status)
                        STATUS_DUPLICATE: dup_hits++;
                        STATUS_NO_MATCH:  miss_hits++;
                        STATUS_FULL:      full_hits++;
                        default: ;
                    endcase
                    if (got.accept !== want.accept)
                    begin
                        $error("accept: expected %0d, got %0d", want.accept, got.accept);
                        fail_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.pending_count !== want.pending_count)
                    begin
                        $error("pending_count: expected %0d, got %0d",
                               want.pending_count, got.pending_count);
                        fail_count++;
                    end
                end
            end
            if (msg.valid && msg.ready)
            begin
                verdict_q.insert(verdict_q.size(), apply_header(msg.req_type,
                    {msg.service_id, msg.method_id, msg.client_id, msg.session_id}));
                if (live_total > peak_pending)
                    peak_pending = live_total;
            end
            awaiting = verdict_q.size();
        end
    end

endmodule

FILE: tb/sv/pending_request_tracker_tb.sv
`timescale 1ns / 100ps
// pending_request_tracker_tb: drives headers into the tracker and throttles its results.
// Depends on prt_pkg, prt_if, prt_checker and the tracker RTL.
module pending_request_tracker_tb;
    import prt_pkg::*;

    localparam int DEPTH        = PRT_TABLE_DEPTH;
    localparam int RANDOM_ITEMS = 1500;
    localparam int ROUND_LEN    = 120;
    localparam int HOLD_CYCLES  = 700;
    localparam int TAIL_CYCLES  = 2 * (DEPTH + 3);
    localparam int CYCLE_LIMIT  = 1_500_000;

    // Message kinds that leave the table alone
    localparam logic [KIND_W-1:0] KIND_NO_RETURN = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NOTIFY    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

    localparam logic [KEY_W-1:0] KEY_A    = 64'h1234_5678_9ABC_DEF0;
    localparam logic [KEY_W-1:0] KEY_SVC1 = {16'hFFFF, 48'h0};

    logic clk = 1'b0;
    logic rst_n;
    bit   flood_phase = 1'b0;
    int   sent_count = 0;
    int   cycle_count = 0;
    int   burst_left = 0;

    int fail_count, awaiting, checked, dup_hits, miss_hits, full_hits, peak_pending;

    // Requests sent and not yet answered, as seen by the sender
    logic [KEY_W-1:0] open_requests [$];

    prt_msg_if    msg_ch ();
    prt_result_if result_ch ();

    pending_request_tracker #(.TABLE_DEPTH(DEPTH)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .result (result_ch)
    );

    prt_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg          (msg_ch),
        .result       (result_ch),
        .fail_count   (fail_count),
        .awaiting     (awaiting),
        .checked      (checked),
        .dup_hits     (dup_hits),
        .miss_hits    (miss_hits),
        .full_hits    (full_hits),
        .peak_pending (peak_pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding", cycle_count, awaiting);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] fresh_key();
        return {$urandom, $urandom};
    endfunction

    // Offer one header and hold it until the tracker takes it
    task automatic send_header(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
        @(negedge clk);
        msg_ch.valid    <= 1'b1;
        msg_ch.req_type <= kind;
        {msg_ch.service_id, msg_ch.method_id, msg_ch.client_id, msg_ch.session_id} <= key;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        sent_count++;
    endtask

    // Between bursts of transactions, insert an idle gap or none
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(2) == 0)
                gap = 0;
            else if ($urandom_range(4) == 0)
                gap = $urandom_range(20, 80);
            else
                gap = $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                msg_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    // Hold result ready at one level for a number of cycles
    task automatic drive_ready(input bit level, input int cycles);
        @(negedge clk);
        result_ch.ready <= level;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Result side: one long hold-off once flooding starts, then a stall pattern
    initial
    begin
        bit held;
        held = 1'b0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (flood_phase && !held)
            begin
                held = 1'b1;
                drive_ready(1'b0, HOLD_CYCLES);
            end
            case ($urandom_range(9))
                0: drive_ready(1'b1, 300);
                1: drive_ready(1'b0, $urandom_range(30, 90));
                default:
                begin
                    drive_ready(1'b1, $urandom_range(1, 20));
                    drive_ready(1'b0, $urandom_range(1, 6));
                end
            endcase
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        int                req_pct;
        int                roll;
        int                pick;
        int                lane;

        rst_n              = 1'b0;
        msg_ch.valid       = 1'b0;
        msg_ch.req_type    = '0;
        msg_ch.service_id  = '0;
        msg_ch.method_id   = '0;
        msg_ch.client_id   = '0;
        msg_ch.session_id  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme keys, every kind, duplicates, near-miss responses, slot reuse
        send_header(KIND_REQUEST, '0);
        send_header(KIND_REQUEST, '0);
        send_header(KIND_REQUEST, '1);
        send_header(KIND_NO_RETURN, '1);
        send_header(KIND_NOTIFY, '0);
        send_header(KIND_OTHER, '1);
        send_header(KIND_SPARE_LO, '0);
        send_header(KIND_SPARE_HI, '1);
        send_header(KIND_RESPONSE, '1);
        send_header(KIND_RESPONSE, '1);
        send_header(KIND_ERROR, '0);
        send_header(KIND_ERROR, '0);
        send_header(KIND_REQUEST, KEY_A);
        send_header(KIND_RESPONSE, KEY_A ^ 64'h1);
        send_header(KIND_ERROR, KEY_A ^ (64'h1 << 48));
        send_header(KIND_RESPONSE, KEY_A ^ (64'h1 << 32));
        send_header(KIND_REQUEST, KEY_SVC1);
        send_header(KIND_RESPONSE, KEY_A);
        send_header(KIND_ERROR, KEY_SVC1);
        send_header(KIND_REQUEST, KEY_A);
        send_header(KIND_RESPONSE, KEY_A);

        // Random: rounds that fill, mix and drain the table
        flood_phase = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ((n / ROUND_LEN) % 4)
                0: req_pct = 90;
                1: req_pct = 50;
                2: req_pct = 15;
                default: req_pct = 70;
            endcase
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                // table-neutral kinds, fully random key
                case ($urandom_range(4))
                    0: kind = KIND_NO_RETURN;
                    1: kind = KIND_NOTIFY;
                    2: kind = KIND_OTHER;
                    3: kind = KIND_SPARE_LO;
                    default: kind = KIND_SPARE_HI;
                endcase
                key = fresh_key();
            end
            else if (roll < 8 + (req_pct * 92) / 100)
            begin
                kind = KIND_REQUEST;
                if (open_requests.size() > 0 && $urandom_range(99) < 15)
                begin
                    pick = $urandom_range(open_requests.size() - 1);
                    key  = open_requests[pick];
                end
                else
                begin
                    key = fresh_key();
                    open_requests.insert(open_requests.size(), key);
                end
            end
            else
            begin
                kind = $urandom_range(1) ? KIND_RESPONSE : KIND_ERROR;
                if (open_requests.size() > 0 && $urandom_range(99) < 85)
                begin
                    pick = $urandom_range(open_requests.size() - 1);
                    key  = open_requests[pick];
                    // now and then flip one bit of one identifier
                    if ($urandom_range(7) == 0)
                    begin
                        lane = $urandom_range(3);
                        key[16*lane +: 16] = key[16*lane +: 16] ^ (16'h1 << $urandom_range(15));
                    end
                    else
                    begin
                        open_requests.delete(pick);
                    end
                end
                else
                begin
                    key = fresh_key();
                end
            end
            pace_sender();
            send_header(kind, key);
        end

        @(negedge clk);
        msg_ch.valid <= 1'b0;

        // Drain, then let the tracker settle
        while (awaiting != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d headers, %0d results: %0d duplicates, %0d unmatched, %0d full drops",
                 sent_count, checked, dup_hits, miss_hits, full_hits);
        $display("Peak table occupancy %0d of %0d entries, %0d mismatches",
                 peak_pending, DEPTH, fail_count);
        if (fail_count == 0 && awaiting == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
